### src/fdnr_pkg.sv
// Shared types, constants and helper functions for the feedback delay network reverb.
// No dependencies; fdnr_if, fdnr_bfly and the top level use this package.
`timescale 1ns / 1ps

package fdnr_pkg;

    localparam int NUM_LINES      = 16;
    localparam int LINE_BITS      = 4;
    localparam int LINE_CAPACITY  = 4096;
    localparam int POS_BITS       = 12;
    localparam int ADDR_BITS      = LINE_BITS + POS_BITS;
    localparam int STORE_DEPTH    = NUM_LINES * LINE_CAPACITY;
    localparam int SAMPLE_BITS    = 24;
    localparam int STORE_BITS     = SAMPLE_BITS + 4;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PROD_BITS      = STORE_BITS + COEF_BITS;
    localparam int NUM_STAGES     = 4;
    localparam int HALF_LINES     = NUM_LINES / 2;
    localparam int CNT_BITS       = LINE_BITS + 1;
    localparam int STAGE_BITS     = 2;
    localparam int WET_BITS       = STORE_BITS + 6;
    localparam int CFG_IDX_BITS   = 8;

    localparam logic signed [COEF_BITS-1:0] FB_COEF  = 18'sd58982;
    localparam logic signed [COEF_BITS-1:0] COS_INIT = 18'sd46341;
    localparam logic signed [COEF_BITS-1:0] SIN_INIT = 18'sd46341;

    localparam logic [CFG_IDX_BITS-1:0] REG_ROT_COS = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROT_SIN = 8'd1;

    typedef logic [POS_BITS-1:0]          t_pos;
    typedef logic signed [STORE_BITS-1:0] t_store;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]  t_coef;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_BFLY,
        S_BLOAD,
        S_WRITE,
        S_DONE
    } t_state;

    function automatic t_pos line_len(input logic [LINE_BITS-1:0] idx);
        t_pos len;
        case (idx)
            4'd0:    len = 12'd882;
            4'd1:    len = 12'd950;
            4'd2:    len = 12'd1099;
            4'd3:    len = 12'd1022;
            4'd4:    len = 12'd1473;
            4'd5:    len = 12'd1369;
            4'd6:    len = 12'd1183;
            4'd7:    len = 12'd1273;
            4'd8:    len = 12'd2646;
            4'd9:    len = 12'd2460;
            4'd10:   len = 12'd2125;
            4'd11:   len = 12'd2286;
            4'd12:   len = 12'd1585;
            4'd13:   len = 12'd1706;
            4'd14:   len = 12'd1975;
            4'd15:   len = 12'd1835;
            default: len = 12'd882;
        endcase
        return len;
    endfunction

    function automatic t_pos wrap_inc(input t_pos pos, input t_pos len);
        t_pos nxt;
        nxt = pos + 12'd1;
        if (nxt >= len) begin
            nxt = '0;
        end
        return nxt;
    endfunction

    function automatic t_store sat_store(input logic signed [PROD_BITS+1:0] v);
        t_store res;
        if (v > (PROD_BITS+2)'($signed({1'b0, {(STORE_BITS-1){1'b1}}}))) begin
            res = {1'b0, {(STORE_BITS-1){1'b1}}};
        end else if (v < (PROD_BITS+2)'($signed({1'b1, {(STORE_BITS-1){1'b0}}}))) begin
            res = {1'b1, {(STORE_BITS-1){1'b0}}};
        end else begin
            res = v[STORE_BITS-1:0];
        end
        return res;
    endfunction

    function automatic t_sample sat_sample(input logic signed [WET_BITS-1:0] v);
        t_sample res;
        if (v > WET_BITS'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (v < WET_BITS'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

### src/fdnr_if.sv
// Handshake channel interfaces: stereo input, stereo wet output and register writes.
// Depends on fdnr_pkg for field widths.
`timescale 1ns / 1ps

interface fdnr_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fdnr_pkg::SAMPLE_BITS-1:0] left_in;
    logic signed [fdnr_pkg::SAMPLE_BITS-1:0] right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface fdnr_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fdnr_pkg::SAMPLE_BITS-1:0] wet_left;
    logic signed [fdnr_pkg::SAMPLE_BITS-1:0] wet_right;
    modport source (output valid, output wet_left, output wet_right, input ready);
    modport sink (input valid, input wet_left, input wet_right, output ready);
endinterface

interface fdnr_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [fdnr_pkg::CFG_IDX_BITS-1:0]      index;
    logic signed [fdnr_pkg::COEF_BITS-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/fdnr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fdnr_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/fdnr_bfly.sv
// Rotation butterfly: four registered products, then rounding, sum and saturation.
// Depends on fdnr_pkg.
`timescale 1ns / 1ps

module fdnr_bfly (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  fdnr_pkg::t_store i_x0,
    input  fdnr_pkg::t_store i_x1,
    input  fdnr_pkg::t_coef  i_a,
    input  fdnr_pkg::t_coef  i_b,
    output logic            o_vld,
    output fdnr_pkg::t_store o_lo,
    output fdnr_pkg::t_store o_hi
);
    import fdnr_pkg::*;

    logic                           r_vld;
    logic signed [PROD_BITS-1:0]    r_ax0, r_bx1, r_ax1, r_bx0;
    logic signed [PROD_BITS:0]      w_sum_lo, w_sum_hi;
    logic signed [PROD_BITS:0]      w_shl, w_shh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_ax0 <= PROD_BITS'(i_a * i_x0);
            r_bx1 <= PROD_BITS'(i_b * i_x1);
            r_ax1 <= PROD_BITS'(i_a * i_x1);
            r_bx0 <= PROD_BITS'(i_b * i_x0);
        end
    end

    always_comb begin
        w_sum_lo = (PROD_BITS+1)'(r_ax0) + (PROD_BITS+1)'(r_bx1)
                 + (PROD_BITS+1)'(1 << (COEF_FRAC_BITS - 1));
        w_sum_hi = (PROD_BITS+1)'(r_ax1) - (PROD_BITS+1)'(r_bx0)
                 + (PROD_BITS+1)'(1 << (COEF_FRAC_BITS - 1));
        w_shl    = w_sum_lo >>> COEF_FRAC_BITS;
        w_shh    = w_sum_hi >>> COEF_FRAC_BITS;
    end

    assign o_vld = r_vld;
    assign o_lo  = sat_store((PROD_BITS+2)'(w_shl));
    assign o_hi  = sat_store((PROD_BITS+2)'(w_shh));

endmodule

### src/feedback_delay_network_reverb_unit.sv
// Top level of the 16-line feedback delay network reverb: sequencer, delay store, mixing.
// Depends on fdnr_pkg, fdnr_if, fdnr_ram and fdnr_bfly.
`timescale 1ns / 1ps

// Channel   Role    Beat
// i_in      sink    left_in, right_in (signed 24 bit)
// o_out     source  wet_left, wet_right (signed 24 bit, saturated)
// i_cfg     sink    index, data (rotation_cos = 0, rotation_sin = 1)
//
// Each item runs through the 16 delay store reads, four butterfly stages on the shared
// rotation unit and the 16 feedback writes, then loads the result and goes back to idle
// for the next beat; the load waits while an unread result still holds the output.
// After reset every word of the delay store is cleared before the first item is taken.
// A finished result waits in the output register; the next item is taken meanwhile.
// Register writes are always taken.

module feedback_delay_network_reverb_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    fdnr_in_if.sink    i_in,
    fdnr_out_if.source o_out,
    fdnr_cfg_if.sink   i_cfg
);
    import fdnr_pkg::*;

    t_state                   r_state, n_state;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [STAGE_BITS-1:0]    r_stage;
    logic [ADDR_BITS-1:0]     r_clr;
    t_pos                     r_pos [NUM_LINES];
    t_store                   r_v [NUM_LINES];
    t_store                   r_lo [HALF_LINES];
    t_store                   r_hi [HALF_LINES];
    t_coef                    r_cos, r_sin;
    t_store                   r_avg;
    logic signed [WET_BITS-1:0] r_wl, r_wr;
    logic                     r_rd_vld;
    logic [LINE_BITS-1:0]     r_rd_line;
    logic                     r_fb_vld;
    logic [LINE_BITS-1:0]     r_fb_line;
    logic signed [PROD_BITS-1:0] r_fb_prod;
    logic                     r_out_vld;
    t_sample                  r_wet_l, r_wet_r;

    logic                     w_in_acc, w_rd_issue, w_bf_issue, w_fb_issue, w_out_load;
    logic [LINE_BITS-1:0]     w_line;
    t_pos                     w_p, w_r;
    logic                     w_wr_en;
    logic [ADDR_BITS-1:0]     w_wr_addr;
    t_store                   w_wr_data;
    t_store                   w_rd_data;
    logic                     w_bf_vld;
    t_store                   w_bf_lo, w_bf_hi;
    logic signed [WET_BITS-1:0] w_t;
    logic signed [PROD_BITS:0]  w_fb_rnd;
    logic [SAMPLE_BITS:0]       w_in_sum;

    assign w_line   = r_cnt[LINE_BITS-1:0];
    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_p      = wrap_inc(r_pos[w_line], line_len(w_line));
    assign w_r      = wrap_inc(w_p, line_len(w_line));
    assign w_in_sum = (SAMPLE_BITS+1)'(i_in.left_in) + (SAMPLE_BITS+1)'(i_in.right_in);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == {ADDR_BITS{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) n_state = S_READ;
            end
            S_READ: begin
                if (r_cnt == CNT_BITS'(NUM_LINES)) n_state = S_BFLY;
            end
            S_BFLY: begin
                if (r_cnt == CNT_BITS'(HALF_LINES)) n_state = S_BLOAD;
            end
            S_BLOAD: begin
                n_state = (r_stage == STAGE_BITS'(NUM_STAGES - 1)) ? S_WRITE : S_BFLY;
            end
            S_WRITE: begin
                if (r_cnt == CNT_BITS'(NUM_LINES)) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        w_rd_issue = (r_state == S_READ) && (r_cnt < CNT_BITS'(NUM_LINES));
        w_bf_issue = (r_state == S_BFLY) && (r_cnt < CNT_BITS'(HALF_LINES));
        w_fb_issue = (r_state == S_WRITE) && (r_cnt < CNT_BITS'(NUM_LINES));
        w_out_load = (r_state == S_DONE) && (!r_out_vld || o_out.ready);
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_stage  <= '0;
            r_clr    <= '0;
            r_rd_vld <= 1'b0;
            r_fb_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_cos    <= COS_INIT;
            r_sin    <= SIN_INIT;
            for (int i = 0; i < NUM_LINES; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_issue;
            r_fb_vld <= w_fb_issue;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ADDR_BITS'(1);
            end
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (r_state == S_READ || r_state == S_BFLY || r_state == S_WRITE) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
            if (r_state == S_IDLE) begin
                r_stage <= '0;
            end else if (r_state == S_BLOAD) begin
                r_stage <= r_stage + STAGE_BITS'(1);
            end
            if (w_rd_issue) begin
                r_pos[w_line] <= w_p;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_ROT_COS) begin
                    r_cos <= i_cfg.data;
                end else if (i_cfg.index == REG_ROT_SIN) begin
                    r_sin <= i_cfg.data;
                end
            end
        end
    end

    always_comb begin
        case (r_rd_line[1:0])
            2'd0:    w_t = WET_BITS'(w_rd_data) <<< 1;
            2'd1:    w_t = -WET_BITS'(w_rd_data);
            2'd2:    w_t = -(WET_BITS'(w_rd_data) <<< 1);
            default: w_t = WET_BITS'(w_rd_data);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_avg <= STORE_BITS'($signed(w_in_sum[SAMPLE_BITS:1]));
            r_wl  <= '0;
            r_wr  <= '0;
        end
        if (w_rd_issue) begin
            r_rd_line <= w_line;
        end
        if (r_rd_vld) begin
            r_wl <= r_wl + w_t;
            case (r_rd_line[1:0])
                2'd0:    r_wr <= r_wr + WET_BITS'(w_rd_data);
                2'd1:    r_wr <= r_wr + (WET_BITS'(w_rd_data) <<< 1);
                2'd2:    r_wr <= r_wr - WET_BITS'(w_rd_data);
                default: r_wr <= r_wr - (WET_BITS'(w_rd_data) <<< 1);
            endcase
        end
        if (r_rd_vld) begin
            for (int i = 0; i < NUM_LINES - 1; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[NUM_LINES-1] <= w_rd_data;
        end else if (w_bf_issue) begin
            for (int i = 0; i < NUM_LINES - 2; i++) begin
                r_v[i] <= r_v[i+2];
            end
        end else if (r_state == S_BLOAD) begin
            for (int i = 0; i < HALF_LINES; i++) begin
                r_v[i]            <= r_lo[i];
                r_v[i+HALF_LINES] <= r_hi[i];
            end
        end else if (w_fb_issue) begin
            for (int i = 0; i < NUM_LINES - 1; i++) begin
                r_v[i] <= r_v[i+1];
            end
        end
        if (w_bf_vld) begin
            for (int i = 0; i < HALF_LINES - 1; i++) begin
                r_lo[i] <= r_lo[i+1];
                r_hi[i] <= r_hi[i+1];
            end
            r_lo[HALF_LINES-1] <= w_bf_lo;
            r_hi[HALF_LINES-1] <= w_bf_hi;
        end
        if (w_fb_issue) begin
            r_fb_prod <= PROD_BITS'(FB_COEF * r_v[0]);
            r_fb_line <= w_line;
        end
        if (w_out_load) begin
            r_wet_l <= sat_sample(r_wl >>> 1);
            r_wet_r <= sat_sample(r_wr >>> 1);
        end
    end

    assign w_fb_rnd = ((PROD_BITS+1)'(r_fb_prod) + (PROD_BITS+1)'(1 << (COEF_FRAC_BITS - 1)))
                    >>> COEF_FRAC_BITS;

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = r_fb_vld;
            w_wr_addr = {r_fb_line, r_pos[r_fb_line]};
            w_wr_data = sat_store((PROD_BITS+2)'(w_fb_rnd) + (PROD_BITS+2)'(r_avg));
        end
    end

    fdnr_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_issue),
        .i_rd_addr ({w_line, w_r}),
        .o_rd_data (w_rd_data)
    );

    fdnr_bfly u_bfly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_bf_issue),
        .i_x0    (r_v[0]),
        .i_x1    (r_v[1]),
        .i_a     (r_cos),
        .i_b     (r_sin),
        .o_vld   (w_bf_vld),
        .o_lo    (w_bf_lo),
        .o_hi    (w_bf_hi)
    );

    assign o_out.valid     = r_out_vld;
    assign o_out.wet_left  = r_wet_l;
    assign o_out.wet_right = r_wet_r;

    a_no_input_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input taken while the delay store is being cleared");

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_READ) && (r_cnt == '0))
        else $error("accepted beat did not start the read sweep");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the completion step");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fb_vld && r_rd_vld))
        else $error("feedback write overlaps a line read");

endmodule
